### rtl/fsg_pkg.sv
// Shared types, constants and helpers of the falling sand grid.
package fsg_pkg;

    localparam int GRID_W_DEF     = 100;
    localparam int GRID_H_DEF     = 160;
    localparam int MAX_GRAINS_DEF = 16384;

    localparam int X_BITS    = 7;
    localparam int Y_BITS    = 8;
    localparam int COL_BITS  = 2;
    localparam int CLR_BITS  = 14;
    localparam int CLEAR_MAX = 16383;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef enum logic [1:0] {
        REQ_PLACE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [X_BITS-1:0]   cell_x;
        logic [Y_BITS-1:0]   cell_y;
        logic [COL_BITS-1:0] grain_color;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          done_type;
        logic                placed;
        logic                table_full;
        logic                occupied;
        logic [COL_BITS-1:0] cell_color;
        logic [CLR_BITS-1:0] cleared_count;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_CELL, S_FIN,
        S_F_NEXT, S_F_G, S_F_D, S_F_S1, S_F_S2, S_F_MV1, S_F_MV2,
        S_B_ROW, S_B_START, S_B_POP, S_B_CUR, S_B_NB, S_B_CHK,
        S_B_SW, S_B_SW1, S_B_SW2, S_B_SW3, S_B_NEXT
    } t_state;

    typedef enum logic [1:0] {
        STEP_DEC,
        STEP_KEEP,
        STEP_INC
    } t_step;

    typedef struct packed {
        t_step dx;
        t_step dy;
    } t_nb;

    // eight neighbors of a cell, one per direction count
    function automatic t_nb nb_of(logic [2:0] dir);
        t_nb r;
        case (dir)
            3'd0: r = '{STEP_DEC,  STEP_DEC};
            3'd1: r = '{STEP_KEEP, STEP_DEC};
            3'd2: r = '{STEP_INC,  STEP_DEC};
            3'd3: r = '{STEP_DEC,  STEP_KEEP};
            3'd4: r = '{STEP_INC,  STEP_KEEP};
            3'd5: r = '{STEP_DEC,  STEP_INC};
            3'd6: r = '{STEP_KEEP, STEP_INC};
            default: r = '{STEP_INC, STEP_INC};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] lfsr_next(logic [31:0] s);
        return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
    endfunction

endpackage

### rtl/fsg_ram.sv
// Generic simple dual-port RAM with registered read.
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

### rtl/falling_sand_grid_with_band_clear.sv
// Falling sand grid: place, read and tick with band clearing, held in RAMs.
//
//  channel | direction | handshake               | payload
//  in      | into      | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | out of    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | into      | i_cfg_we                | i_cfg_wdata (LFSR seed)
//
// Place and read go through S_CELL and S_FIN to the result register; no new item
// is taken before that. A tick lets each grain fall (a dead or bottom-row grain
// stays, others drop straight down or else to a free diagonal), then for each
// occupied left-column row floods its band of one color through eight neighbors
// and sweeps it, clearing the band if it reaches the right column.
// After reset a clearing pass over all GRID_W*GRID_H cells empties the cell and
// visit RAMs; no item is taken meanwhile. Output stall only holds the final
// hand-off; a new item is accepted while a result waits.
module falling_sand_grid_with_band_clear #(
    parameter int GRID_W     = fsg_pkg::GRID_W_DEF,
    parameter int GRID_H     = fsg_pkg::GRID_H_DEF,
    parameter int MAX_GRAINS = fsg_pkg::MAX_GRAINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsg_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsg_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata
);
    import fsg_pkg::*;

    localparam int CELLS = GRID_W * GRID_H;
    localparam int CW    = $clog2(CELLS);
    localparam int QCW   = $clog2(CELLS + 1);
    localparam int GW    = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
    localparam int NW    = $clog2(MAX_GRAINS + 1);
    localparam int CDW   = GW + 1 + COL_BITS;
    localparam int GDW   = X_BITS + Y_BITS + COL_BITS + 1;
    localparam int QDW   = X_BITS + Y_BITS;
    localparam logic [X_BITS-1:0] XMAX = X_BITS'(GRID_W - 1);
    localparam logic [Y_BITS-1:0] YMAX = Y_BITS'(GRID_H - 1);

    function automatic logic [CW-1:0] f_idx(logic [X_BITS-1:0] x, logic [Y_BITS-1:0] y);
        return CW'(32'(y) * GRID_W + 32'(x));
    endfunction

    t_state    r_state, n_state;
    t_in_item  r_req;
    t_out_item r_res, n_res;
    t_out_item r_out;
    logic      r_out_valid;
    logic [NW-1:0]  r_count, n_count;
    logic [31:0]    r_lfsr, n_lfsr;
    logic [NW-1:0]  r_i, n_i;
    logic [GW-1:0]  r_gaddr, n_gaddr;
    logic [X_BITS-1:0] r_gx, n_gx, r_nx, n_nx, r_cx, n_cx;
    logic [Y_BITS-1:0] r_gy, n_gy, r_ny, n_ny, r_cy, n_cy, r_row, n_row;
    logic [COL_BITS-1:0] r_gcol, n_gcol, r_col, n_col;
    logic           r_side, n_side, r_reached, n_reached;
    logic [QCW-1:0] r_head, n_head, r_tail, n_tail, r_k, n_k, r_acc, n_acc, r_clr, n_clr;
    logic [2:0]     r_dir, n_dir;
    logic [CW-1:0]  r_cidx, n_cidx;
    logic [GW-1:0]  r_owner, n_owner;

    // memory ports
    logic           c_we, g_we, v_we, q_we;
    logic [CW-1:0]  c_waddr, c_raddr, v_waddr, v_raddr, q_waddr, q_raddr;
    logic [GW-1:0]  g_waddr, g_raddr;
    logic [CDW-1:0] c_wdata, c_rdata;
    logic [GDW-1:0] g_wdata, g_rdata;
    logic           v_wdata, v_rdata;
    logic [QDW-1:0] q_wdata, q_rdata;

    fsg_ram #(.WIDTH(CDW), .DEPTH(CELLS)) u_cell (
        .i_clk, .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata));
    fsg_ram #(.WIDTH(GDW), .DEPTH(MAX_GRAINS)) u_grain (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata));
    fsg_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (
        .i_clk, .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata));
    fsg_ram #(.WIDTH(QDW), .DEPTH(CELLS)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));

    // read data fields
    logic                cd_occ;
    logic [COL_BITS-1:0] cd_col;
    logic [GW-1:0]       cd_own;
    logic [X_BITS-1:0]   gd_x;
    logic [Y_BITS-1:0]   gd_y;
    logic [COL_BITS-1:0] gd_col;
    logic                gd_live;
    assign cd_occ  = c_rdata[CDW-1];
    assign cd_col  = c_rdata[GW +: COL_BITS];
    assign cd_own  = c_rdata[GW-1:0];
    assign gd_x    = g_rdata[GDW-1 -: X_BITS];
    assign gd_y    = g_rdata[COL_BITS+1 +: Y_BITS];
    assign gd_col  = g_rdata[1 +: COL_BITS];
    assign gd_live = g_rdata[0];

    logic w_accept, w_load, w_full, w_inr, w_clr_done, w_last_dir;
    logic [NW-1:0] w_gnext;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_load     = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_full     = (r_count == NW'(MAX_GRAINS));
    assign w_inr      = (32'(r_req.cell_x) < GRID_W) && (32'(r_req.cell_y) < GRID_H);
    assign w_clr_done = (r_clr == QCW'(CELLS - 1));
    assign w_last_dir = (r_dir == 3'd7);
    assign w_gnext    = r_i - NW'(1);

    // diagonal candidates: first the side from the LFSR, then the other one
    logic w_side, w_fst_ok, w_alt_ok;
    logic [X_BITS-1:0] w_fst_x, w_alt_x;
    assign w_side   = (r_state == S_F_D) ? r_lfsr[0] : r_side;
    assign w_fst_ok = w_side ? (r_gx != XMAX) : (r_gx != '0);
    assign w_alt_ok = w_side ? (r_gx != '0) : (r_gx != XMAX);
    assign w_fst_x  = w_side ? r_gx + X_BITS'(1) : r_gx - X_BITS'(1);
    assign w_alt_x  = w_side ? r_gx - X_BITS'(1) : r_gx + X_BITS'(1);

    // flood neighbor
    t_nb w_nb;
    logic w_nb_ok, w_match;
    logic [X_BITS-1:0] w_nbx;
    logic [Y_BITS-1:0] w_nby;
    assign w_nb = nb_of(r_dir);
    always_comb begin
        w_nb_ok = 1'b1;
        w_nbx   = r_cx;
        w_nby   = r_cy;
        case (w_nb.dx)
            STEP_DEC: begin
                w_nb_ok = (r_cx != '0);
                w_nbx   = r_cx - X_BITS'(1);
            end
            STEP_INC: begin
                w_nb_ok = (r_cx != XMAX);
                w_nbx   = r_cx + X_BITS'(1);
            end
            default: ;
        endcase
        case (w_nb.dy)
            STEP_DEC: begin
                w_nb_ok = w_nb_ok && (r_cy != '0);
                w_nby   = r_cy - Y_BITS'(1);
            end
            STEP_INC: begin
                w_nb_ok = w_nb_ok && (r_cy != YMAX);
                w_nby   = r_cy + Y_BITS'(1);
            end
            default: ;
        endcase
    end
    assign w_match = cd_occ && !v_rdata && (cd_col == r_col);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (w_clr_done) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.req_type)
                        REQ_PLACE, REQ_READ: n_state = S_CELL;
                        REQ_TICK:            n_state = S_F_NEXT;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_CELL:   n_state = S_FIN;
            S_FIN:    if (w_load) n_state = S_IDLE;
            S_F_NEXT: n_state = (r_i == '0) ? S_B_ROW : S_F_G;
            S_F_G:    n_state = (!gd_live || gd_y == YMAX) ? S_F_NEXT : S_F_D;
            S_F_D: begin
                if (!cd_occ)       n_state = S_F_MV1;
                else if (w_fst_ok) n_state = S_F_S1;
                else if (w_alt_ok) n_state = S_F_S2;
                else               n_state = S_F_NEXT;
            end
            S_F_S1: begin
                if (!cd_occ)       n_state = S_F_MV1;
                else if (w_alt_ok) n_state = S_F_S2;
                else               n_state = S_F_NEXT;
            end
            S_F_S2:    n_state = cd_occ ? S_F_NEXT : S_F_MV1;
            S_F_MV1:   n_state = S_F_MV2;
            S_F_MV2:   n_state = S_F_NEXT;
            S_B_ROW:   n_state = S_B_START;
            S_B_START: n_state = cd_occ ? S_B_POP : S_B_NEXT;
            S_B_POP:   n_state = (r_head == r_tail) ? S_B_SW : S_B_CUR;
            S_B_CUR:   n_state = S_B_NB;
            S_B_NB: begin
                if (w_nb_ok)         n_state = S_B_CHK;
                else if (w_last_dir) n_state = S_B_POP;
            end
            S_B_CHK:   n_state = w_last_dir ? S_B_POP : S_B_NB;
            S_B_SW:    n_state = (r_k == r_tail) ? S_B_NEXT : S_B_SW1;
            S_B_SW1:   n_state = r_reached ? S_B_SW2 : S_B_SW;
            S_B_SW2:   n_state = S_B_SW3;
            S_B_SW3:   n_state = S_B_SW;
            S_B_NEXT:  n_state = (r_row == '0) ? S_FIN : S_B_ROW;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_res = r_res;   n_count = r_count; n_lfsr = r_lfsr;   n_i = r_i;
        n_gaddr = r_gaddr; n_gx = r_gx;   n_gy = r_gy;       n_gcol = r_gcol;
        n_nx = r_nx;     n_ny = r_ny;     n_cx = r_cx;       n_cy = r_cy;
        n_row = r_row;   n_col = r_col;   n_side = r_side;   n_reached = r_reached;
        n_head = r_head; n_tail = r_tail; n_k = r_k;         n_acc = r_acc;
        n_clr = r_clr;   n_dir = r_dir;   n_cidx = r_cidx;   n_owner = r_owner;
        c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_raddr = '0;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_raddr = '0;
        v_we = 1'b0; v_waddr = '0; v_wdata = 1'b0; v_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        case (r_state)
            S_CLR: begin
                c_we    = 1'b1;
                c_waddr = r_clr[CW-1:0];
                v_we    = 1'b1;
                v_waddr = r_clr[CW-1:0];
                n_clr   = r_clr + QCW'(1);
            end
            S_IDLE: begin
                c_raddr = f_idx(i_in_item.cell_x, i_in_item.cell_y);
                if (w_accept) begin
                    n_res           = '0;
                    n_res.done_type = i_in_item.req_type;
                    n_i             = r_count;
                    n_acc           = '0;
                end
            end
            S_CELL: begin
                if (r_req.req_type == REQ_PLACE) begin
                    n_res.table_full = w_full;
                    if (w_inr && !w_full && !cd_occ) begin
                        c_we    = 1'b1;
                        c_waddr = f_idx(r_req.cell_x, r_req.cell_y);
                        c_wdata = {1'b1, r_req.grain_color, r_count[GW-1:0]};
                        g_we    = 1'b1;
                        g_waddr = r_count[GW-1:0];
                        g_wdata = {r_req.cell_x, r_req.cell_y, r_req.grain_color, 1'b1};
                        n_count = r_count + NW'(1);
                        n_res.placed = 1'b1;
                    end
                end else if (w_inr && cd_occ) begin
                    n_res.occupied   = 1'b1;
                    n_res.cell_color = cd_col;
                end
            end
            S_F_NEXT: begin
                g_raddr = w_gnext[GW-1:0];
                n_gaddr = w_gnext[GW-1:0];
                n_row   = YMAX;
                if (r_i != '0) n_i = w_gnext;
            end
            S_F_G: begin
                n_gx    = gd_x;
                n_gy    = gd_y;
                n_gcol  = gd_col;
                n_nx    = gd_x;
                n_ny    = gd_y + Y_BITS'(1);
                c_raddr = f_idx(gd_x, gd_y + Y_BITS'(1));
            end
            S_F_D: begin
                if (cd_occ) begin
                    n_side = r_lfsr[0];
                    n_lfsr = lfsr_next(r_lfsr);
                    if (w_fst_ok) begin
                        n_nx    = w_fst_x;
                        c_raddr = f_idx(w_fst_x, r_ny);
                    end else begin
                        n_nx    = w_alt_x;
                        c_raddr = f_idx(w_alt_x, r_ny);
                    end
                end
            end
            S_F_S1: begin
                n_nx    = cd_occ ? w_alt_x : r_nx;
                c_raddr = f_idx(w_alt_x, r_ny);
            end
            S_F_MV1: begin
                c_we    = 1'b1;
                c_waddr = f_idx(r_nx, r_ny);
                c_wdata = {1'b1, r_gcol, r_gaddr};
                g_we    = 1'b1;
                g_waddr = r_gaddr;
                g_wdata = {r_nx, r_ny, r_gcol, 1'b1};
            end
            S_F_MV2: begin
                c_we    = 1'b1;
                c_waddr = f_idx(r_gx, r_gy);
            end
            S_B_ROW: c_raddr = f_idx('0, r_row);
            S_B_START: begin
                n_col     = cd_col;
                n_head    = '0;
                n_tail    = QCW'(1);
                n_reached = 1'b0;
                q_we      = cd_occ;
                q_waddr   = '0;
                q_wdata   = {X_BITS'(0), r_row};
                v_we      = cd_occ;
                v_waddr   = f_idx('0, r_row);
                v_wdata   = 1'b1;
            end
            S_B_POP: begin
                q_raddr = r_head[CW-1:0];
                n_k     = '0;
            end
            S_B_CUR: begin
                n_cx   = q_rdata[QDW-1 -: X_BITS];
                n_cy   = q_rdata[Y_BITS-1:0];
                n_head = r_head + QCW'(1);
                n_dir  = '0;
                if (q_rdata[QDW-1 -: X_BITS] == XMAX) n_reached = 1'b1;
            end
            S_B_NB: begin
                c_raddr = f_idx(w_nbx, w_nby);
                v_raddr = f_idx(w_nbx, w_nby);
                n_nx    = w_nbx;
                n_ny    = w_nby;
                if (!w_nb_ok) n_dir = r_dir + 3'd1;
            end
            S_B_CHK: begin
                n_dir = r_dir + 3'd1;
                if (w_match) begin
                    v_we    = 1'b1;
                    v_waddr = f_idx(r_nx, r_ny);
                    v_wdata = 1'b1;
                    q_we    = 1'b1;
                    q_waddr = r_tail[CW-1:0];
                    q_wdata = {r_nx, r_ny};
                    n_tail  = r_tail + QCW'(1);
                end
            end
            S_B_SW: begin
                q_raddr = r_k[CW-1:0];
                if (r_k == r_tail && r_reached) n_acc = r_acc + r_tail;
            end
            S_B_SW1: begin
                n_cidx  = f_idx(q_rdata[QDW-1 -: X_BITS], q_rdata[Y_BITS-1:0]);
                v_we    = 1'b1;
                v_waddr = f_idx(q_rdata[QDW-1 -: X_BITS], q_rdata[Y_BITS-1:0]);
                c_raddr = f_idx(q_rdata[QDW-1 -: X_BITS], q_rdata[Y_BITS-1:0]);
                n_k     = r_k + QCW'(1);
            end
            S_B_SW2: begin
                n_owner = cd_own;
                g_raddr = cd_own;
                c_we    = 1'b1;
                c_waddr = r_cidx;
            end
            S_B_SW3: begin
                g_we    = 1'b1;
                g_waddr = r_owner;
                g_wdata = {g_rdata[GDW-1:1], 1'b0};
            end
            S_B_NEXT: begin
                if (r_row == '0) begin
                    n_res.cleared_count = (32'(r_acc) > CLEAR_MAX) ?
                                          CLR_BITS'(CLEAR_MAX) : CLR_BITS'(r_acc);
                end else begin
                    n_row = r_row - Y_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_lfsr      <= 32'd1;
            r_clr       <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_lfsr <= (i_cfg_wdata == '0) ? 32'd1 : i_cfg_wdata;
            end else begin
                r_lfsr <= n_lfsr;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_req <= i_in_item;
        if (w_load)   r_out <= r_res;
        r_res <= n_res;     r_i <= n_i;         r_gaddr <= n_gaddr;
        r_gx <= n_gx;       r_gy <= n_gy;       r_gcol <= n_gcol;
        r_nx <= n_nx;       r_ny <= n_ny;       r_cx <= n_cx;      r_cy <= n_cy;
        r_row <= n_row;     r_col <= n_col;     r_side <= n_side;
        r_reached <= n_reached;
        r_head <= n_head;   r_tail <= n_tail;   r_k <= n_k;        r_acc <= n_acc;
        r_dir <= n_dir;     r_cidx <= n_cidx;   r_owner <= n_owner;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule
